>>> rtl/core/tpra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpra_pkg
// Shared constants and the arctangent table for the two-point rotation core.
// ----------------------------------------------------------------------------
package tpra_pkg;

  localparam int COORD_BITS   = 12;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int GUARD_BITS   = 8;
  localparam int OUT_BITS     = 16;
  localparam int TABLE_LEN    = 24;
  localparam int NUM_FIELDS   = 8;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN32 [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // table entry reduced to Ab-bit turn units, rounded half up
  function automatic logic [31:0] atan_entry(input int Step, input int Ab);
    logic [32:0] e;
    e = {1'b0, ATAN_TURN32[Step % TABLE_LEN]} + (33'd1 << (31 - Ab));
    return 32'(e >> (32 - Ab));
  endfunction

endpackage

>>> rtl/core/tpra_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpra_prep
// Forms both difference vectors, scales them and folds the left half-plane.
// ----------------------------------------------------------------------------
module tpra_prep #(
  parameter int COORD_BITS = tpra_pkg::COORD_BITS,
  parameter int ANGLE_BITS = tpra_pkg::ANGLE_BITS,
  parameter int W          = COORD_BITS + tpra_pkg::GUARD_BITS + 3
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [tpra_pkg::NUM_FIELDS*COORD_BITS-1:0]  in_data,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [1:0][W-1:0]                           out_x,
  output logic [1:0][W-1:0]                           out_y,
  output logic [1:0][ANGLE_BITS-1:0]                  out_z,
  output logic [1:0]                                  out_zero
);

  logic [1:0][W-1:0]          x_next;
  logic [1:0][W-1:0]          y_next;
  logic [1:0][ANGLE_BITS-1:0] z_next;
  logic [1:0]                 zero_next;

  always_comb begin
    logic [COORD_BITS-1:0] fx, fy, sx, sy;
    logic [COORD_BITS:0]   dx, dy;
    logic [W-1:0]          xs, ys;
    for (int k = 0; k < 2; k++) begin
      fx = in_data[(4*k+0)*COORD_BITS +: COORD_BITS];
      fy = in_data[(4*k+1)*COORD_BITS +: COORD_BITS];
      sx = in_data[(4*k+2)*COORD_BITS +: COORD_BITS];
      sy = in_data[(4*k+3)*COORD_BITS +: COORD_BITS];
      dx = {1'b0, sx} - {1'b0, fx};
      dy = {1'b0, sy} - {1'b0, fy};
      xs = W'($signed(dx)) <<< tpra_pkg::GUARD_BITS;
      ys = W'($signed(dy)) <<< tpra_pkg::GUARD_BITS;
      zero_next[k] = (dx == '0) && (dy == '0);
      if (dx[COORD_BITS]) begin
        x_next[k] = -xs;
        y_next[k] = -ys;
        z_next[k] = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
      end else begin
        x_next[k] = xs;
        y_next[k] = ys;
        z_next[k] = '0;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_z    <= z_next;
      out_zero <= zero_next;
    end
  end

endmodule

>>> rtl/core/tpra_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpra_cell
// One CORDIC vectoring iteration for the current and reference vectors.
// ----------------------------------------------------------------------------
module tpra_cell #(
  parameter int ANGLE_BITS = tpra_pkg::ANGLE_BITS,
  parameter int W          = tpra_pkg::COORD_BITS + tpra_pkg::GUARD_BITS + 3,
  parameter int STEP       = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0][W-1:0]          in_x,
  input  logic [1:0][W-1:0]          in_y,
  input  logic [1:0][ANGLE_BITS-1:0] in_z,
  input  logic [1:0]                 in_zero,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0][W-1:0]          out_x,
  output logic [1:0][W-1:0]          out_y,
  output logic [1:0][ANGLE_BITS-1:0] out_z,
  output logic [1:0]                 out_zero
);

  localparam logic [ANGLE_BITS-1:0] T =
    ANGLE_BITS'(tpra_pkg::atan_entry(STEP, ANGLE_BITS));

  logic [1:0][W-1:0]          x_next;
  logic [1:0][W-1:0]          y_next;
  logic [1:0][ANGLE_BITS-1:0] z_next;

  always_comb begin
    logic [W-1:0] xs, ys;
    for (int k = 0; k < 2; k++) begin
      xs = W'($signed(in_x[k]) >>> STEP);
      ys = W'($signed(in_y[k]) >>> STEP);
      if (!in_y[k][W-1]) begin
        x_next[k] = in_x[k] + ys;
        y_next[k] = in_y[k] - xs;
        z_next[k] = in_z[k] + T;
      end else begin
        x_next[k] = in_x[k] - ys;
        y_next[k] = in_y[k] + xs;
        z_next[k] = in_z[k] - T;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_z    <= z_next;
      out_zero <= in_zero;
    end
  end

endmodule

>>> rtl/core/tpra_wrap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpra_wrap
// Subtracts the reference angle, wraps it and rescales to the output width.
// ----------------------------------------------------------------------------
module tpra_wrap #(
  parameter int ANGLE_BITS = tpra_pkg::ANGLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0][ANGLE_BITS-1:0]          in_z,
  input  logic [1:0]                          in_zero,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tpra_pkg::OUT_BITS-1:0] out_data
);

  logic [ANGLE_BITS-1:0]         cur;
  logic [ANGLE_BITS-1:0]         ref_angle;
  logic [ANGLE_BITS-1:0]         d;
  logic [32:0]                   aligned;
  logic [32:0]                   rounded;
  logic [tpra_pkg::OUT_BITS-1:0] data_next;

  assign cur       = in_zero[0] ? '0 : in_z[0];
  assign ref_angle = in_zero[1] ? '0 : in_z[1];
  assign d         = cur - ref_angle;
  assign aligned   = 33'(d) << (32 - ANGLE_BITS);
  assign rounded   = aligned + (33'd1 << (31 - tpra_pkg::OUT_BITS));
  assign data_next = rounded[31 -: tpra_pkg::OUT_BITS];

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= $signed(data_next);
    end
  end

endmodule

>>> rtl/core/two_point_rotation_angle_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_point_rotation_angle_core
// Rotation angle of a two-finger touch between a reference and current frame.
//
//   channel  dir  fields (lowest bit up)
//   s_axis   in   cur_first_x, cur_first_y, cur_second_x, cur_second_y,
//                 ref_first_x, ref_first_y, ref_second_x, ref_second_y
//   m_axis   out  angle_delta
//
// One beat in per cycle while m_axis is not stalled, one beat out per input beat, in order.
// The pipeline is a setup stage, one cell per CORDIC iteration and the
// output register.
// Reset clears all stage valid flags; no clearing pass.
// A stall on m_axis backs up stage by stage; bubbles are squeezed out.
// ----------------------------------------------------------------------------
module two_point_rotation_angle_core #(
  parameter int COORD_BITS   = tpra_pkg::COORD_BITS,
  parameter int ANGLE_BITS   = tpra_pkg::ANGLE_BITS,
  parameter int CORDIC_STEPS = tpra_pkg::CORDIC_STEPS
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // cur_first_x, cur_first_y, cur_second_x, cur_second_y,
  // ref_first_x, ref_first_y, ref_second_x, ref_second_y
  input  logic [tpra_pkg::NUM_FIELDS*COORD_BITS-1:0] s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // angle_delta
  output logic signed [tpra_pkg::OUT_BITS-1:0]       m_axis_tdata
);

  localparam int W = COORD_BITS + tpra_pkg::GUARD_BITS + 3;

  logic [CORDIC_STEPS:0]                       valid;
  logic [CORDIC_STEPS:0]                       ready;
  logic [CORDIC_STEPS:0][1:0][W-1:0]           x;
  logic [CORDIC_STEPS:0][1:0][W-1:0]           y;
  logic [CORDIC_STEPS:0][1:0][ANGLE_BITS-1:0]  z;
  logic [CORDIC_STEPS:0][1:0]                  zero;

  tpra_prep #(
    .COORD_BITS (COORD_BITS),
    .ANGLE_BITS (ANGLE_BITS),
    .W          (W)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .out_valid (valid[0]),
    .out_ready (ready[0]),
    .out_x     (x[0]),
    .out_y     (y[0]),
    .out_z     (z[0]),
    .out_zero  (zero[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    tpra_cell #(
      .ANGLE_BITS (ANGLE_BITS),
      .W          (W),
      .STEP       (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[i]),
      .in_ready  (ready[i]),
      .in_x      (x[i]),
      .in_y      (y[i]),
      .in_z      (z[i]),
      .in_zero   (zero[i]),
      .out_valid (valid[i+1]),
      .out_ready (ready[i+1]),
      .out_x     (x[i+1]),
      .out_y     (y[i+1]),
      .out_z     (z[i+1]),
      .out_zero  (zero[i+1])
    );
  end

  tpra_wrap #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_wrap (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid[CORDIC_STEPS]),
    .in_ready  (ready[CORDIC_STEPS]),
    .in_z      (z[CORDIC_STEPS]),
    .in_zero   (zero[CORDIC_STEPS]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("pipeline not empty after reset");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with output stage empty");

  a_drain_ready: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

endmodule
